FILE: design/rpt_pkg.sv
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types and codes for the regex pattern tokenizer: transfer payloads,
// parse state, token kinds and parse mode codes.
// ----------------------------------------------------------------------------
package rpt_pkg;

  // Width of the brace count accumulators; counts saturate at all ones.
  localparam int unsigned COUNT_BITS = 10;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Width of the repeat count fields in a token.
  localparam int unsigned REPEAT_BITS = 10;

  // One character can cause at most four tokens.
  localparam int unsigned MAX_TOKENS   = 4;
  localparam int unsigned TOK_CNT_BITS = $clog2(MAX_TOKENS + 1);

  // Parse mode codes.
  localparam logic [2:0] MODE_NORMAL      = 3'd0;
  localparam logic [2:0] MODE_CLASS_FIRST = 3'd1;
  localparam logic [2:0] MODE_CLASS       = 3'd2;
  localparam logic [2:0] MODE_CLASS_RANGE = 3'd3;
  localparam logic [2:0] MODE_BRACE_MIN   = 3'd4;
  localparam logic [2:0] MODE_BRACE_MAX   = 3'd5;

  // Token kinds.
  localparam logic [2:0] TOK_ELEM    = 3'd0;
  localparam logic [2:0] TOK_OR      = 3'd1;
  localparam logic [2:0] TOK_CLOSURE = 3'd2;
  localparam logic [2:0] TOK_OPEN    = 3'd3;
  localparam logic [2:0] TOK_CLOSE   = 3'd4;
  localparam logic [2:0] TOK_CONCAT  = 3'd5;
  localparam logic [2:0] TOK_END     = 3'd6;

  // Input transfer payload.
  typedef struct packed {
    logic [7:0] pattern_char;
    logic       first_char;
    logic       last_char;
  } in_t;

  // Output transfer payload: one token.
  typedef struct packed {
    logic [2:0]             token_kind;
    logic                   negated;
    logic [7:0]             low_char;
    logic [7:0]             high_char;
    logic [REPEAT_BITS-1:0] min_repeat;
    logic [REPEAT_BITS-1:0] max_repeat;
    logic                   unbounded;
    logic                   anchored_start;
    logic                   anchored_end;
    logic                   last_token;
  } out_t;

  // Parse state carried from one character to the next.
  typedef struct packed {
    logic [2:0]            parse_mode;
    logic                  item_done;
    logic                  class_negated;
    logic                  class_started;
    logic                  pending_valid;
    logic [7:0]            pending_char;
    logic [COUNT_BITS-1:0] min_accum;
    logic [COUNT_BITS-1:0] max_accum;
    logic                  max_seen_digit;
    logic                  start_anchor;
    logic                  end_anchor;
  } state_t;

  localparam state_t STATE_RESET = '0;

  // Tokens caused by one character, first token in slot 0.
  typedef struct packed {
    out_t [MAX_TOKENS-1:0]   tok;
    logic [TOK_CNT_BITS-1:0] count;
  } tok_set_t;

endpackage

FILE: design/rpt_decode.sv
// ----------------------------------------------------------------------------
// rpt_decode
// Combinational tokenizer step: from the current parse state and one pattern
// character, computes the tokens it causes and the next parse state.
// ----------------------------------------------------------------------------
module rpt_decode (
  input  rpt_pkg::in_t      in_data_i,
  input  rpt_pkg::state_t   state_i,
  output rpt_pkg::state_t   state_o,
  output rpt_pkg::tok_set_t toks_o
);
  import rpt_pkg::*;

  state_t                  st;
  tok_set_t                ts;
  logic [7:0]              c;
  logic                    is_digit;
  logic                    do_member;
  logic                    do_fresh;
  logic [7:0]              mem_lo;
  logic [7:0]              mem_hi;

  // Build a token with every field that does not belong to it at zero.
  function automatic out_t mk_tok(input logic [2:0] kind, input logic neg,
                                  input logic [7:0] lo, input logic [7:0] hi,
                                  input logic [COUNT_BITS-1:0] mn,
                                  input logic [COUNT_BITS-1:0] mx,
                                  input logic unb, input logic sa, input logic ea);
    out_t t;
    t                = '0;
    t.token_kind     = kind;
    t.negated        = neg;
    t.low_char       = lo;
    t.high_char      = hi;
    t.min_repeat     = REPEAT_BITS'(mn);
    t.max_repeat     = REPEAT_BITS'(mx);
    t.unbounded      = unb;
    t.anchored_start = sa;
    t.anchored_end   = ea;
    return t;
  endfunction

  function automatic out_t simple_tok(input logic [2:0] kind);
    return mk_tok(kind, 1'b0, 8'd0, 8'd0, '0, '0, 1'b0, 1'b0, 1'b0);
  endfunction

  // Append one decimal digit to a count, saturating at the top.
  function automatic logic [COUNT_BITS-1:0] sat_digit(input logic [COUNT_BITS-1:0] acc,
                                                      input logic [3:0] d);
    logic [COUNT_BITS+3:0] ext;
    logic [COUNT_BITS+3:0] v;
    ext = {4'd0, acc};
    v   = (ext << 3) + (ext << 1) + {{COUNT_BITS{1'b0}}, d};
    if (v > {4'd0, COUNT_MAX}) begin
      return COUNT_MAX;
    end
    return v[COUNT_BITS-1:0];
  endfunction

  assign c        = in_data_i.pattern_char;
  assign is_digit = (c >= "0") && (c <= "9");

  // Each append below writes the next free slot; a character causes at most
  // four tokens, so the slot index never wraps.
  always_comb begin
    st        = in_data_i.first_char ? STATE_RESET : state_i;
    ts        = '0;
    do_member = 1'b0;
    do_fresh  = 1'b0;
    mem_lo    = st.pending_char;
    mem_hi    = st.pending_char;

    case (st.parse_mode)
      MODE_CLASS_FIRST: begin
        st.parse_mode = MODE_CLASS;
        if (c == "^") begin
          st.class_negated = 1'b1;
        end else begin
          do_fresh = 1'b1;
        end
      end
      MODE_CLASS: begin
        if (!st.pending_valid) begin
          do_fresh = 1'b1;
        end else if (c == "-") begin
          st.parse_mode = MODE_CLASS_RANGE;
        end else begin
          do_member = 1'b1;
          do_fresh  = 1'b1;
        end
      end
      MODE_CLASS_RANGE: begin
        do_member     = 1'b1;
        mem_hi        = c;
        st.parse_mode = MODE_CLASS;
      end
      MODE_BRACE_MIN: begin
        if (is_digit) begin
          st.min_accum = sat_digit(st.min_accum, c[3:0]);
        end else if (c == ",") begin
          st.parse_mode     = MODE_BRACE_MAX;
          st.max_accum      = '0;
          st.max_seen_digit = 1'b0;
        end else if (c == "}") begin
          ts.tok[ts.count[1:0]] = mk_tok(TOK_CLOSURE, 1'b0, 8'd0, 8'd0, st.min_accum, '0,
                                         1'b1, 1'b0, 1'b0);
          ts.count      = ts.count + 1'b1;
          st.parse_mode = MODE_NORMAL;
          st.item_done  = 1'b1;
        end
      end
      MODE_BRACE_MAX: begin
        if (is_digit) begin
          st.max_accum      = sat_digit(st.max_accum, c[3:0]);
          st.max_seen_digit = 1'b1;
        end else if (c == "}") begin
          if (st.max_seen_digit) begin
            ts.tok[ts.count[1:0]] = mk_tok(TOK_CLOSURE, 1'b0, 8'd0, 8'd0, st.min_accum,
                                           st.max_accum, 1'b0, 1'b0, 1'b0);
          end else begin
            ts.tok[ts.count[1:0]] = mk_tok(TOK_CLOSURE, 1'b0, 8'd0, 8'd0, st.min_accum,
                                           '0, 1'b1, 1'b0, 1'b0);
          end
          ts.count      = ts.count + 1'b1;
          st.parse_mode = MODE_NORMAL;
          st.item_done  = 1'b1;
        end
      end
      default: begin
        // Outside brackets and braces; unused mode codes behave as normal.
        st.parse_mode = MODE_NORMAL;
        case (c)
          "[": begin
            if (st.item_done) begin
              ts.tok[ts.count[1:0]] = simple_tok(TOK_CONCAT);
              ts.count              = ts.count + 1'b1;
            end
            st.parse_mode    = MODE_CLASS_FIRST;
            st.class_negated = 1'b0;
            st.class_started = 1'b0;
            st.pending_valid = 1'b0;
          end
          "|": begin
            ts.tok[ts.count[1:0]] = simple_tok(TOK_OR);
            ts.count              = ts.count + 1'b1;
            st.item_done          = 1'b0;
          end
          "+": begin
            ts.tok[ts.count[1:0]] = mk_tok(TOK_CLOSURE, 1'b0, 8'd0, 8'd0,
                                           COUNT_BITS'(1), '0, 1'b1, 1'b0, 1'b0);
            ts.count              = ts.count + 1'b1;
            st.item_done          = 1'b1;
          end
          "?": begin
            ts.tok[ts.count[1:0]] = mk_tok(TOK_CLOSURE, 1'b0, 8'd0, 8'd0,
                                           '0, COUNT_BITS'(1), 1'b0, 1'b0, 1'b0);
            ts.count              = ts.count + 1'b1;
            st.item_done          = 1'b1;
          end
          "*": begin
            ts.tok[ts.count[1:0]] = mk_tok(TOK_CLOSURE, 1'b0, 8'd0, 8'd0,
                                           '0, '0, 1'b1, 1'b0, 1'b0);
            ts.count              = ts.count + 1'b1;
            st.item_done          = 1'b1;
          end
          "{": begin
            st.parse_mode     = MODE_BRACE_MIN;
            st.min_accum      = '0;
            st.max_accum      = '0;
            st.max_seen_digit = 1'b0;
          end
          "(": begin
            if (st.item_done) begin
              ts.tok[ts.count[1:0]] = simple_tok(TOK_CONCAT);
              ts.count              = ts.count + 1'b1;
            end
            ts.tok[ts.count[1:0]] = simple_tok(TOK_OPEN);
            ts.count              = ts.count + 1'b1;
            st.item_done          = 1'b0;
          end
          ")": begin
            ts.tok[ts.count[1:0]] = simple_tok(TOK_CLOSE);
            ts.count              = ts.count + 1'b1;
            st.item_done          = 1'b1;
          end
          "^": begin
            st.start_anchor = 1'b1;
          end
          "$": begin
            st.end_anchor = 1'b1;
          end
          ".": begin
            if (st.item_done) begin
              ts.tok[ts.count[1:0]] = simple_tok(TOK_CONCAT);
              ts.count              = ts.count + 1'b1;
            end
            ts.tok[ts.count[1:0]] = mk_tok(TOK_ELEM, 1'b0, 8'd0, 8'd127, '0, '0,
                                           1'b0, 1'b0, 1'b0);
            ts.count              = ts.count + 1'b1;
            st.item_done          = 1'b1;
          end
          default: begin
            if (st.item_done) begin
              ts.tok[ts.count[1:0]] = simple_tok(TOK_CONCAT);
              ts.count              = ts.count + 1'b1;
            end
            ts.tok[ts.count[1:0]] = mk_tok(TOK_ELEM, 1'b0, c, c, '0, '0,
                                           1'b0, 1'b0, 1'b0);
            ts.count              = ts.count + 1'b1;
            st.item_done          = 1'b1;
          end
        endcase
      end
    endcase

    // Emit a held class member: open before the first member, or between.
    if (do_member) begin
      ts.tok[ts.count[1:0]] = simple_tok(st.class_started ? TOK_OR : TOK_OPEN);
      ts.count              = ts.count + 1'b1;
      st.class_started      = 1'b1;
      ts.tok[ts.count[1:0]] = mk_tok(TOK_ELEM, st.class_negated, mem_lo, mem_hi, '0, '0,
                                     1'b0, 1'b0, 1'b0);
      ts.count              = ts.count + 1'b1;
      st.pending_valid      = 1'b0;
    end

    // A fresh class character either closes the class or is held as a member.
    if (do_fresh) begin
      if (c == "]") begin
        ts.tok[ts.count[1:0]] = simple_tok(TOK_CLOSE);
        ts.count              = ts.count + 1'b1;
        st.parse_mode         = MODE_NORMAL;
        st.item_done          = 1'b1;
      end else begin
        st.pending_char  = c;
        st.pending_valid = 1'b1;
      end
    end

    // The final character adds the end token and clears the parse state.
    if (in_data_i.last_char) begin
      ts.tok[ts.count[1:0]] = mk_tok(TOK_END, 1'b0, 8'd0, 8'd0, '0, '0, 1'b0,
                                     st.start_anchor, st.end_anchor);
      ts.count              = ts.count + 1'b1;
      st                    = STATE_RESET;
    end

    // Flag the last token caused by this character.
    if (ts.count != '0) begin
      ts.tok[ts.count[1:0] - 2'd1].last_token = 1'b1;
    end

    state_o = st;
    toks_o  = ts;
  end

endmodule

FILE: design/regex_pattern_tokenizer_top.sv
// The first token of a character is offered in the cycle after the character's transfer.
// A character that causes k tokens (k up to 4) holds the token buffer until the last leaves;
// the next character is taken in the cycle its last token leaves, and characters that cause
// none are taken one per cycle. The single output port, one token per ready cycle, sets the rate.
// Reset (rst_ni low, asynchronous) clears the parse state and drops any buffered tokens.
// ----------------------------------------------------------------------------
// regex_pattern_tokenizer_top
// Regex pattern tokenizer: takes one pattern character per transfer and emits
// element, alternation, closure, group, concatenation and end tokens.
// ----------------------------------------------------------------------------
module regex_pattern_tokenizer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rpt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rpt_pkg::out_t out_data_o
);
  import rpt_pkg::*;

  state_t                  state_q;
  state_t                  state_d;
  state_t                  dec_state;
  tok_set_t                dec_toks;
  out_t [MAX_TOKENS-1:0]   slot_q;
  out_t [MAX_TOKENS-1:0]   slot_d;
  logic [TOK_CNT_BITS-1:0] cnt_q;
  logic [TOK_CNT_BITS-1:0] cnt_d;
  logic                    in_xfer;
  logic                    out_xfer;

  // Tokenizer step for the character on the input port.
  rpt_decode u_decode (
    .in_data_i (in_data_i),
    .state_i   (state_q),
    .state_o   (dec_state),
    .toks_o    (dec_toks)
  );

  // Accept a character when the buffer is empty or its last token leaves now.
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = slot_q[0];
  assign out_xfer    = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q == '0) ||
                       ((cnt_q == TOK_CNT_BITS'(1)) && out_ready_i);
  assign in_xfer     = in_valid_i && in_ready_o;

  // Token buffer: load a new set, or shift one token out per transfer.
  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    cnt_d   = cnt_q;
    if (in_xfer) begin
      state_d = dec_state;
      slot_d  = dec_toks.tok;
      cnt_d   = dec_toks.count;
    end else if (out_xfer) begin
      for (int i = 0; i < MAX_TOKENS - 1; i++) begin
        slot_d[i] = slot_q[i+1];
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Token payload.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

FILE: design/rpt_checker.sv
// ----------------------------------------------------------------------------
// rpt_checker
// Port-level checks for the regex pattern tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module rpt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input rpt_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input rpt_pkg::out_t out_data_o
);
  import rpt_pkg::*;

  // A stalled token stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled token changed or was withdrawn");

  // The final character always leaves at least an end token behind.
  a_last_gives_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_char |=> out_valid_o)
    else $error("no token offered after the final character");

  // The end token is always the last token of its character.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.token_kind == TOK_END) |-> out_data_o.last_token)
    else $error("end token without last token flag");

  // The maximum repeat is zero outside closures and when unbounded.
  a_repeat_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.token_kind != TOK_CLOSURE) || out_data_o.unbounded) |->
      (out_data_o.max_repeat == '0))
    else $error("max repeat set where it does not belong");

endmodule

bind regex_pattern_tokenizer_top rpt_checker u_rpt_checker (.*);
